FILE: hw/rtl/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, codes and helpers for the integer to ascii digit converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int unsigned ValueWidthDef = 32;
  localparam logic [30:0] CountMax = 31'h7fff_ffff;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharALow  = 8'h61;
  localparam logic [7:0] CharMinus = 8'h2d;

  typedef enum logic [1:0] {
    OP_SDEC = 2'd0,
    OP_UDEC = 2'd1,
    OP_HEX  = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] value;
  } itoa_in_t;

  typedef struct packed {
    logic [7:0]  ascii_char;
    logic        last;
    logic [30:0] total_written;
  } itoa_out_t;

  function automatic logic [7:0] digit_to_ascii(logic [3:0] digit);
    logic [7:0] ch;
    if (digit < 4'd10) begin
      ch = CharZero + {4'h0, digit};
    end else begin
      ch = CharALow + {4'h0, digit} - 8'd10;
    end
    return ch;
  endfunction

endpackage

FILE: hw/rtl/itoa_dabble_step.sv
// ----------------------------------------------------------------------------
// itoa_dabble_step
// One shift-and-add-3 step of the binary to bcd converter.
// ----------------------------------------------------------------------------
module itoa_dabble_step #(
  parameter int unsigned NumDigits = 12
) (
  input  logic [NumDigits*4-1:0] bcd_i,
  input  logic                   bit_i,
  output logic [NumDigits*4-1:0] bcd_o
);

  logic [NumDigits*4-1:0] adj;

  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_i[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd_i[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = bcd_i[i*4 +: 4];
      end
    end
  end

  assign bcd_o = {adj[NumDigits*4-2:0], bit_i};

endmodule

FILE: hw/rtl/integer_to_ascii_digits.sv
// Decimal numbers are converted by double dabble in S_CONV, hex numbers are loaded directly;
// then S_SKIP drops leading zero digits, keeping at least one, before the first character.
// Characters then leave at one per cycle while the output is not stalled, after a leading minus if negative.
// A new transaction is taken once the last character is in the output register.
// Reset clears the sequencer, output valid and the running character total.
// ----------------------------------------------------------------------------
// integer_to_ascii_digits
// Converts a number to ascii characters, signed/unsigned decimal or hex.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits #(
  parameter int unsigned VALUE_WIDTH = itoa_pkg::ValueWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  itoa_pkg::itoa_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output itoa_pkg::itoa_out_t out_data_o
);

  import itoa_pkg::*;

  localparam int unsigned NumDigits = (VALUE_WIDTH * 1233) / 4096 + 2;
  localparam int unsigned HexDigits = (VALUE_WIDTH + 3) / 4;
  localparam int unsigned BcdW      = NumDigits * 4;
  localparam int unsigned BitCntW   = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned DigCntW   = $clog2(NumDigits + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_SIGN,
    S_EMIT
  } state_e;

  state_e                 state_q, state_d;
  logic [VALUE_WIDTH-1:0] bin_q, bin_d;
  logic [BcdW-1:0]        bcd_q, bcd_d;
  logic [BitCntW-1:0]     bcnt_q, bcnt_d;
  logic [DigCntW-1:0]     dcnt_q, dcnt_d;
  logic                   neg_q, neg_d;
  logic [30:0]            count_q, count_d;
  logic                   out_valid_q, out_valid_d;
  itoa_out_t              out_data_q, out_data_d;

  logic [VALUE_WIDTH-1:0] val;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   val_neg;
  logic [BcdW-1:0]        step_bcd;
  logic                   slot_free;
  logic                   push;
  logic [7:0]             push_char;
  logic                   push_last;
  logic [30:0]            count_inc;

  itoa_dabble_step #(
    .NumDigits(NumDigits)
  ) u_step (
    .bcd_i(bcd_q),
    .bit_i(bin_q[VALUE_WIDTH-1]),
    .bcd_o(step_bcd)
  );

  assign val       = VALUE_WIDTH'(in_data_i.value);
  assign val_neg   = (in_data_i.op == OP_SDEC) && val[VALUE_WIDTH-1];
  assign mag       = val_neg ? (VALUE_WIDTH'(0) - val) : val;
  assign slot_free = !out_valid_q || !out_stall_i;
  assign count_inc = (count_q == CountMax) ? count_q : count_q + 31'd1;

  always_comb begin
    state_d   = state_q;
    bin_d     = bin_q;
    bcd_d     = bcd_q;
    bcnt_d    = bcnt_q;
    dcnt_d    = dcnt_q;
    neg_d     = neg_q;
    push      = 1'b0;
    push_char = CharMinus;
    push_last = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && (in_data_i.op != OP_NONE)) begin
          neg_d = val_neg;
          if (in_data_i.op == OP_HEX) begin
            bcd_d   = BcdW'(mag) << (BcdW - 4 * HexDigits);
            dcnt_d  = DigCntW'(HexDigits);
            state_d = S_SKIP;
          end else begin
            bin_d   = mag;
            bcd_d   = '0;
            bcnt_d  = BitCntW'(VALUE_WIDTH);
            state_d = S_CONV;
          end
        end
      end
      S_CONV: begin
        bcd_d  = step_bcd;
        bin_d  = bin_q << 1;
        bcnt_d = bcnt_q - BitCntW'(1);
        if (bcnt_q == BitCntW'(1)) begin
          dcnt_d  = DigCntW'(NumDigits);
          state_d = S_SKIP;
        end
      end
      S_SKIP: begin
        if ((bcd_q[BcdW-1 -: 4] == 4'h0) && (dcnt_q != DigCntW'(1))) begin
          bcd_d  = {bcd_q[BcdW-5:0], 4'h0};
          dcnt_d = dcnt_q - DigCntW'(1);
        end else begin
          state_d = neg_q ? S_SIGN : S_EMIT;
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          push    = 1'b1;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          push      = 1'b1;
          push_char = digit_to_ascii(bcd_q[BcdW-1 -: 4]);
          push_last = (dcnt_q == DigCntW'(1));
          bcd_d     = {bcd_q[BcdW-5:0], 4'h0};
          dcnt_d    = dcnt_q - DigCntW'(1);
          if (dcnt_q == DigCntW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    count_d     = count_q;
    if (push) begin
      out_valid_d              = 1'b1;
      out_data_d.ascii_char    = push_char;
      out_data_d.last          = push_last;
      out_data_d.total_written = count_inc;
      count_d                  = count_inc;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q      <= bin_d;
    bcd_q      <= bcd_d;
    bcnt_q     <= bcnt_d;
    dcnt_q     <= dcnt_d;
    neg_q      <= neg_d;
    out_data_q <= out_data_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: hw/rtl/itoa_checker.sv
// ----------------------------------------------------------------------------
// itoa_checker
// Port-level checks for the integer to ascii digit converter.
// ----------------------------------------------------------------------------
module itoa_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_i,
  input itoa_pkg::itoa_in_t  in_data_i,
  input logic                out_valid_i,
  input logic                out_stall_i,
  input itoa_pkg::itoa_out_t out_data_i
);

  import itoa_pkg::*;

  // stalled transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled output transaction changed");

  // more characters pending keeps the input side closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.last |-> in_stall_i)
    else $error("input taken while a number is still being emitted");

  // a minus sign is never the final character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.ascii_char == CharMinus) |-> !out_data_i.last)
    else $error("minus sign marked as last");

  // running total counts the character itself
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.total_written != 31'd0))
    else $error("total written is zero on a valid character");

endmodule

bind integer_to_ascii_digits itoa_checker u_itoa_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_i (in_stall_o),
  .in_data_i  (in_data_i),
  .out_valid_i(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_i (out_data_o)
);

FILE: sim/integer_to_ascii_digits_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_digits_tb
// Drives numbers in all three formats and the unused format into the
// converter and checks every character, its last flag and the running
// character total against a predictor kept in step with accepted numbers.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits_tb;
  import itoa_pkg::*;

  localparam int RandomItems = 400;
  localparam int QuietLimit = 3000;
  localparam int HoldoffCycles = 400;
  localparam int HoldoffAfter = 80;
  localparam int EndPause = 100;
  localparam logic [127:0] DigitSet = "0123456789abcdef";

  typedef struct packed {
    logic     drain_first;
    itoa_in_t item;
  } stim_t;

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  itoa_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  itoa_out_t out_data_o;

  stim_t      pending_items[$];
  itoa_out_t  expected_chars[$];
  logic [30:0] char_total = '0;
  logic       in_took = 1'b0;
  int         total_items = 0;
  int         items_taken = 0;
  int         chars_checked = 0;
  int         errors = 0;
  int         quiet_cycles = 0;
  int         holdoff_left = 0;
  bit         holdoff_done = 1'b0;
  int         ops_taken[0:3] = '{default: 0};

  integer_to_ascii_digits u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // idle percentage for the current third of the run
  function automatic int idle_pct(bit sender);
    int third;
    third = (total_items == 0) ? 0 : (items_taken * 3) / total_items;
    if (third == 0) begin
      return sender ? 18 : 59;
    end else if (third == 1) begin
      return sender ? 59 : 18;
    end
    return 0;
  endfunction

  task automatic push_char(input logic [7:0] ch, input logic is_last);
    itoa_out_t exp_char;
    if (char_total < CountMax) begin
      char_total = char_total + 31'd1;
    end
    exp_char.ascii_char    = ch;
    exp_char.last          = is_last;
    exp_char.total_written = char_total;
    expected_chars.push_back(exp_char);
  endtask

  task automatic predict_chars(input itoa_in_t item);
    op_e         fmt;
    logic [31:0] mag;
    logic [31:0] radix;
    logic [7:0]  digits[0:23];
    int          nd;
    int          d;
    int          i;
    bit          neg;
    fmt = op_e'(item.op);
    if (fmt == OP_NONE) begin
      return;
    end
    radix = (fmt == OP_HEX) ? 32'd16 : 32'd10;
    mag = item.value;
    neg = 1'b0;
    if (fmt == OP_SDEC && mag[31]) begin
      neg = 1'b1;
      mag = ~mag + 32'd1;
    end
    nd = 0;
    do begin
      d = int'(mag % radix);
      digits[nd] = DigitSet[8*(15-d) +: 8];
      nd++;
      mag = mag / radix;
    end while (mag != 0);
    if (neg) begin
      push_char(CharMinus, 1'b0);
    end
    for (i = nd - 1; i >= 0; i--) begin
      push_char(digits[i], i == 0);
    end
  endtask

  task automatic add_item(input op_e fmt, input logic [31:0] value, input logic drain);
    stim_t s;
    s.drain_first = drain;
    s.item.op     = fmt;
    s.item.value  = value;
    pending_items.push_back(s);
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] p;
    int          k;
    case ($urandom_range(4))
      0: pick_value = $urandom;
      1: pick_value = $urandom_range(20);
      2: pick_value = $urandom >> $urandom_range(31);
      3: pick_value = 32'd0 - $urandom_range(20);
      default: begin
        p = 32'd1;
        k = $urandom_range(9);
        repeat (k) p = p * 32'd10;
        pick_value = p - 32'd1 + $urandom_range(2);
      end
    endcase
  endfunction

  // monitor: checks characters, then predicts for an accepted number
  always @(posedge clk_i) begin : monitor
    itoa_out_t exp_char;
    in_took <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character %h", $time, out_data_o);
        errors++;
      end else begin
        exp_char = expected_chars.pop_front();
        chars_checked++;
        if (out_data_o.ascii_char !== exp_char.ascii_char) begin
          $display("%0t: ascii_char expected %h got %h", $time,
                   exp_char.ascii_char, out_data_o.ascii_char);
          errors++;
        end
        if (out_data_o.last !== exp_char.last) begin
          $display("%0t: last expected %b got %b", $time, exp_char.last, out_data_o.last);
          errors++;
        end
        if (out_data_o.total_written !== exp_char.total_written) begin
          $display("%0t: total_written expected %0d got %0d", $time,
                   exp_char.total_written, out_data_o.total_written);
          errors++;
        end
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_chars(in_data_i);
      ops_taken[in_data_i.op]++;
      items_taken++;
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni && !(in_valid_i && !in_stall_o) && !(out_valid_o && !out_stall_i)) begin
      quiet_cycles++;
    end else begin
      quiet_cycles = 0;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, QuietLimit);
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk_i) begin : drive_inputs
    logic  offer;
    if (rst_ni) begin
      if (in_took) begin
        pending_items.delete(0);
      end
      if (in_valid_i && !in_took) begin
        offer = 1'b1;
      end else begin
        offer = 1'b0;
        if (pending_items.size() != 0 &&
            !(pending_items[0].drain_first && expected_chars.size() != 0) &&
            $urandom_range(99) >= idle_pct(1'b1)) begin
          offer = 1'b1;
          in_data_i <= pending_items[0].item;
        end
      end
      in_valid_i <= offer;
    end
  end

  always @(negedge clk_i) begin : drive_stall
    if (rst_ni) begin
      if (!holdoff_done && items_taken >= HoldoffAfter) begin
        holdoff_left = HoldoffCycles;
        holdoff_done = 1'b1;
      end
      if (holdoff_left != 0) begin
        holdoff_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < idle_pct(1'b0));
      end
    end
  end

  initial begin
    int  i;
    int  r;
    op_e fmt;
    add_item(OP_SDEC, 32'h0000_0000, 1'b0);
    add_item(OP_SDEC, 32'h0000_0001, 1'b0);
    add_item(OP_SDEC, 32'hffff_ffff, 1'b0);
    add_item(OP_SDEC, 32'h8000_0000, 1'b0);
    add_item(OP_SDEC, 32'h7fff_ffff, 1'b0);
    add_item(OP_SDEC, 32'd9, 1'b0);
    add_item(OP_SDEC, 32'd10, 1'b0);
    add_item(OP_SDEC, 32'hffff_fff6, 1'b0);
    add_item(OP_UDEC, 32'h0000_0000, 1'b0);
    add_item(OP_UDEC, 32'hffff_ffff, 1'b0);
    add_item(OP_UDEC, 32'h8000_0000, 1'b0);
    add_item(OP_UDEC, 32'd999999999, 1'b0);
    add_item(OP_UDEC, 32'd1000000000, 1'b0);
    add_item(OP_HEX, 32'h0000_0000, 1'b0);
    add_item(OP_HEX, 32'hffff_ffff, 1'b0);
    add_item(OP_HEX, 32'h0000_000f, 1'b0);
    add_item(OP_HEX, 32'h0000_0010, 1'b0);
    add_item(OP_HEX, 32'hdead_beef, 1'b0);
    add_item(OP_HEX, 32'h0abc_def0, 1'b0);
    add_item(OP_NONE, 32'hffff_ffff, 1'b1);
    add_item(OP_NONE, 32'h0000_0000, 1'b0);
    add_item(OP_UDEC, 32'd7, 1'b0);
    for (i = 0; i < RandomItems; i++) begin
      r = $urandom_range(19);
      fmt = (r == 0) ? OP_NONE : op_e'(r % 3);
      add_item(fmt, pick_value(), (i % 97) == 50);
    end
    total_items = pending_items.size();

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0 || expected_chars.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (EndPause) @(posedge clk_i);

    if (expected_chars.size() != 0) begin
      $display("%0t: %0d characters never arrived", $time, expected_chars.size());
      errors++;
    end
    $display("numbers sent: %0d signed dec, %0d unsigned dec, %0d hex, %0d unused format",
             ops_taken[OP_SDEC], ops_taken[OP_UDEC], ops_taken[OP_HEX], ops_taken[OP_NONE]);
    $display("characters checked: %0d, mismatches: %0d", chars_checked, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/itoa_pkg.sv
hw/rtl/itoa_dabble_step.sv
hw/rtl/integer_to_ascii_digits.sv
hw/rtl/itoa_checker.sv
sim/integer_to_ascii_digits_tb.sv
